// File: src/soft_start_frequency_ramp_defines.svh
// assertion macros shared by the soft start ramp modules
`ifndef SOFT_START_FREQUENCY_RAMP_DEFINES_SVH
`define SOFT_START_FREQUENCY_RAMP_DEFINES_SVH

// check a property on every clock edge outside reset
`define SSFR_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every clock edge, reset included
`define SSFR_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/ssfr_pkg.sv
// types, constants and helpers of the soft start frequency ramp
`default_nettype none

package ssfr_pkg;

  // field widths
  localparam int FREQ_BITS     = 15;
  localparam int RAW_BITS      = 16;
  localparam int TICK_BITS     = 16;
  localparam int DUTY_BITS     = 10;
  localparam int PERIOD_BITS   = 20;
  localparam int OP_BITS       = 2;
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;

  // period arithmetic
  localparam int MICROS_PER_SEC = 1000000;
  localparam int MIN_PERIOD_US  = 2;
  localparam int MAX_DRIVE_FREQ = MICROS_PER_SEC / MIN_PERIOD_US;
  localparam int DIV_CNT_BITS   = $clog2(PERIOD_BITS);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // register reset values
  localparam logic [FREQ_BITS-1:0] MAX_FREQ_RST      = FREQ_BITS'(1000);
  localparam logic [FREQ_BITS-1:0] STEP_SIZE_RST     = FREQ_BITS'(10);
  localparam logic [TICK_BITS-1:0] STEP_INTERVAL_RST = TICK_BITS'(100);
  localparam logic [FREQ_BITS-1:0] START_FREQ_RST    = FREQ_BITS'(1);
  localparam logic [DUTY_BITS-1:0] DUTY_RST          = DUTY_BITS'(512);

  // item operation codes
  typedef enum logic [OP_BITS-1:0] {
    OP_TICK    = 2'd0,
    OP_SET     = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_MAX_FREQ      = 3'd0,
    REG_STEP_SIZE     = 3'd1,
    REG_STEP_INTERVAL = 3'd2,
    REG_START_FREQ    = 3'd3,
    REG_DUTY_SETTING  = 3'd4
  } reg_idx_t;

  // classified item from the front
  typedef struct packed {
    op_t                  op;
    logic                 reject;
    logic [FREQ_BITS-1:0] freq;
  } cmd_t;

  // back sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } back_state_t;

  // divider status toward the back
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // active flag after applying frequency f
  function automatic logic drive_active(input logic [FREQ_BITS-1:0] f, input logic cur);
    logic res;
    if (f == '0) begin
      res = 1'b0;
    end else if (32'(f) > 32'(MAX_DRIVE_FREQ)) begin
      res = cur;
    end else begin
      res = 1'b1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: src/ssfr_front.sv
// front: accepts items, classifies them and queues them for the back
`default_nettype none

`include "soft_start_frequency_ramp_defines.svh"

module ssfr_front import ssfr_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [OP_BITS-1:0]          in_operation,
  input  wire logic signed [RAW_BITS-1:0]  in_frequency,
  input  wire logic [FREQ_BITS-1:0]        max_freq,
  input  wire logic                        cmd_pop,
  output logic                             cmd_valid,
  output cmd_t                             cmd
);

  localparam logic [QCNT_BITS-1:0] QCNT_MAX = QCNT_BITS'(QUEUE_DEPTH);
  localparam logic [QPTR_BITS-1:0] QPTR_LAST = QPTR_BITS'(QUEUE_DEPTH - 1);
  localparam int CMP_BITS = (FREQ_BITS > RAW_BITS) ? FREQ_BITS : RAW_BITS;

  cmd_t                 q_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r, count_nxt;
  logic                 wr_en;
  logic [RAW_BITS-1:0]  raw;
  cmd_t                 cls;

  // classify the incoming item
  always_comb begin
    raw        = $unsigned(in_frequency);
    cls.op     = op_t'(in_operation);
    cls.freq   = FREQ_BITS'(raw);
    cls.reject = raw[RAW_BITS-1] || (CMP_BITS'(raw) > CMP_BITS'(max_freq));
  end

  // queue flags and pointers
  assign full      = (count_r == QCNT_MAX);
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign wr_en     = push && !full;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_LAST) ? '0 : wr_ptr_r + QPTR_BITS'(1);
    end
    if (cmd_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_LAST) ? '0 : rd_ptr_r + QPTR_BITS'(1);
    end
    if (wr_en && !cmd_pop) begin
      count_nxt = count_r + QCNT_BITS'(1);
    end else if (!wr_en && cmd_pop) begin
      count_nxt = count_r - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  `SSFR_CHECK(a_queue_bound, count_r <= QCNT_MAX, "command queue count above depth")
  `SSFR_CHECK(a_no_pop_empty, cmd_pop |-> cmd_valid, "command popped from empty queue")

endmodule

`default_nettype wire

// File: src/ssfr_div.sv
// iterative restoring divider for the period, one quotient bit per cycle
`default_nettype none

module ssfr_div import ssfr_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [FREQ_BITS-1:0]   divisor,
  output logic [PERIOD_BITS-1:0]      quotient,
  output div_stat_t                   stat
);

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [PERIOD_BITS-1:0]  acc_r, acc_nxt;
  logic [FREQ_BITS-1:0]    rem_r, rem_nxt;
  logic [FREQ_BITS-1:0]    dsr_r, dsr_nxt;
  logic [FREQ_BITS:0]      trial;
  logic                    fits;

  // one shift and trial subtract per cycle
  always_comb begin
    trial    = {rem_r, acc_r[PERIOD_BITS-1]};
    fits     = (trial >= {1'b0, dsr_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_BITS'(PERIOD_BITS - 1);
      acc_nxt  = PERIOD_BITS'(MICROS_PER_SEC);
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      acc_nxt = {acc_r[PERIOD_BITS-2:0], fits};
      rem_nxt = fits ? FREQ_BITS'(trial - {1'b0, dsr_r}) : FREQ_BITS'(trial);
      cnt_nxt = cnt_r - DIV_CNT_BITS'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quotient  = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

// File: src/ssfr_back.sv
// back: ramp state update, period sequencing and the result register
`default_nettype none

`include "soft_start_frequency_ramp_defines.svh"

module ssfr_back import ssfr_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cmd_valid,
  input  wire cmd_t                   cmd,
  output logic                        cmd_pop,
  input  wire logic [FREQ_BITS-1:0]   step_size,
  input  wire logic [TICK_BITS-1:0]   step_interval,
  input  wire logic [FREQ_BITS-1:0]   start_freq,
  input  wire logic [DUTY_BITS-1:0]   duty_setting,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [FREQ_BITS-1:0]        out_current_freq,
  output logic [FREQ_BITS-1:0]        out_target_freq,
  output logic [PERIOD_BITS-1:0]      out_period_us,
  output logic [DUTY_BITS-1:0]        out_duty_out,
  output logic                        out_output_on,
  output logic                        out_status
);

  back_state_t state_r, state_nxt;

  // ramp state
  logic [FREQ_BITS-1:0] target_r, target_nxt;
  logic [FREQ_BITS-1:0] current_r, current_nxt;
  logic [TICK_BITS-1:0] elapsed_r, elapsed_nxt;
  logic                 pending_r, pending_nxt;
  logic                 active_r, active_nxt;

  // result register
  logic [FREQ_BITS-1:0]   res_current_r, res_target_r;
  logic [PERIOD_BITS-1:0] res_period_r;
  logic [DUTY_BITS-1:0]   res_duty_r;
  logic                   res_on_r, res_status_r;
  logic                   status_nxt;

  logic [TICK_BITS-1:0]   elapsed_inc;
  logic [FREQ_BITS:0]     step_sum;
  logic [FREQ_BITS-1:0]   stepped;
  logic                   step_go;
  logic                   take;
  logic                   div_start;
  logic [PERIOD_BITS-1:0] div_q;
  div_stat_t              div_stat;

  ssfr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (current_nxt),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // tick arithmetic
  always_comb begin
    elapsed_inc = (elapsed_r != '1) ? elapsed_r + TICK_BITS'(1) : elapsed_r;
    step_sum    = {1'b0, current_r} + {1'b0, step_size};
    stepped     = (step_sum > {1'b0, target_r}) ? target_r : FREQ_BITS'(step_sum);
    step_go     = (target_r != '0) && (current_r < target_r) &&
                  (elapsed_inc >= step_interval);
  end

  // effect of one item on the ramp state
  always_comb begin
    target_nxt  = target_r;
    current_nxt = current_r;
    elapsed_nxt = elapsed_r;
    pending_nxt = pending_r;
    active_nxt  = active_r;
    status_nxt  = 1'b0;
    case (cmd.op)
      OP_TICK: begin
        elapsed_nxt = elapsed_inc;
        if (step_go) begin
          current_nxt = stepped;
          active_nxt  = drive_active(stepped, active_r);
          elapsed_nxt = '0;
          if (stepped >= target_r) begin
            pending_nxt = 1'b0;
          end
        end
      end
      OP_SET: begin
        if (cmd.reject) begin
          status_nxt = 1'b1;
        end else if (cmd.freq != target_r) begin
          target_nxt = cmd.freq;
          if (cmd.freq == '0) begin
            current_nxt = '0;
            active_nxt  = 1'b0;
          end else if (!pending_r) begin
            current_nxt = start_freq;
            active_nxt  = drive_active(start_freq, active_r);
            elapsed_nxt = '0;
          end
        end
      end
      OP_RESTART: begin
        if (target_r != '0) begin
          pending_nxt = 1'b1;
          current_nxt = start_freq;
          active_nxt  = drive_active(start_freq, active_r);
          elapsed_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    take      = 1'b0;
    div_start = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          take      = 1'b1;
          div_start = active_nxt && (current_nxt != '0);
          state_nxt = div_start ? BK_DIV : BK_HOLD;
        end
      end
      BK_DIV: begin
        if (div_stat.done) begin
          state_nxt = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (pop) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  assign cmd_pop = take;
  assign empty   = (state_r != BK_HOLD);

  // control and ramp state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      target_r  <= '0;
      current_r <= '0;
      elapsed_r <= '0;
      pending_r <= 1'b0;
      active_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (take) begin
        target_r  <= target_nxt;
        current_r <= current_nxt;
        elapsed_r <= elapsed_nxt;
        pending_r <= pending_nxt;
        active_r  <= active_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      res_current_r <= current_nxt;
      res_target_r  <= target_nxt;
      res_duty_r    <= active_nxt ? duty_setting : '0;
      res_on_r      <= active_nxt;
      res_status_r  <= status_nxt;
      res_period_r  <= '0;
    end else if (state_r == BK_DIV && div_stat.done) begin
      res_period_r  <= div_q;
    end
  end

  assign out_current_freq = res_current_r;
  assign out_target_freq  = res_target_r;
  assign out_period_us    = res_period_r;
  assign out_duty_out     = res_duty_r;
  assign out_output_on    = res_on_r;
  assign out_status       = res_status_r;

  `SSFR_CHECK(a_active_nonzero, active_r |-> (current_r != '0), "active with zero frequency")
  `SSFR_CHECK(a_div_tracks_state, (state_r == BK_DIV) |-> (div_stat.busy || div_stat.done), "waiting on idle divider")
  `SSFR_CHECK(a_duty_needs_on, (state_r == BK_HOLD && res_duty_r != '0) |-> res_on_r, "duty shown while output off")
  `SSFR_CHECK(a_period_needs_on, (state_r == BK_HOLD && res_period_r != '0) |-> res_on_r, "period shown while output off")

endmodule

`default_nettype wire

// File: src/soft_start_frequency_ramp.sv
// top level of the soft start frequency ramp: register file and front/back
//
// channel   direction  handshake               payload
// in        input      push / full             in_operation, in_frequency
// out       output     empty / pop             current, target, period, duty, on, status
// cfg       input      psel/penable/pwrite     paddr, pwdata, prdata (pready tied high)
//
// an item goes straight to the result register when the output is off, while one that
// shows a period waits on a restoring divider that produces one quotient bit a cycle
// a two-entry command queue accepts items until full while the back waits on pop
// rst_n is synchronous; after reset all ramp state is zero and registers hold defaults
`default_nettype none

module soft_start_frequency_ramp import ssfr_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // item input
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [OP_BITS-1:0]           in_operation,
  input  wire logic signed [RAW_BITS-1:0]   in_frequency,
  // result output
  output logic                              empty,
  input  wire logic                         pop,
  output logic [FREQ_BITS-1:0]              out_current_freq,
  output logic [FREQ_BITS-1:0]              out_target_freq,
  output logic [PERIOD_BITS-1:0]            out_period_us,
  output logic [DUTY_BITS-1:0]              out_duty_out,
  output logic                              out_output_on,
  output logic                              out_status,
  // configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0]     paddr,
  input  wire logic [CFG_DATA_BITS-1:0]     pwdata,
  output logic [CFG_DATA_BITS-1:0]          prdata,
  output logic                              pready
);

  logic [FREQ_BITS-1:0] max_freq_r;
  logic [FREQ_BITS-1:0] step_size_r;
  logic [TICK_BITS-1:0] step_interval_r;
  logic [FREQ_BITS-1:0] start_freq_r;
  logic [DUTY_BITS-1:0] duty_setting_r;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;
  logic                 cmd_valid;
  logic                 cmd_pop;
  cmd_t                 cmd;

  // register decode
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_freq_r      <= MAX_FREQ_RST;
      step_size_r     <= STEP_SIZE_RST;
      step_interval_r <= STEP_INTERVAL_RST;
      start_freq_r    <= START_FREQ_RST;
      duty_setting_r  <= DUTY_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MAX_FREQ:      max_freq_r      <= pwdata[FREQ_BITS-1:0];
        REG_STEP_SIZE:     step_size_r     <= pwdata[FREQ_BITS-1:0];
        REG_STEP_INTERVAL: step_interval_r <= pwdata[TICK_BITS-1:0];
        REG_START_FREQ:    start_freq_r    <= pwdata[FREQ_BITS-1:0];
        REG_DUTY_SETTING:  duty_setting_r  <= pwdata[DUTY_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      REG_MAX_FREQ:      prdata = CFG_DATA_BITS'(max_freq_r);
      REG_STEP_SIZE:     prdata = CFG_DATA_BITS'(step_size_r);
      REG_STEP_INTERVAL: prdata = CFG_DATA_BITS'(step_interval_r);
      REG_START_FREQ:    prdata = CFG_DATA_BITS'(start_freq_r);
      REG_DUTY_SETTING:  prdata = CFG_DATA_BITS'(duty_setting_r);
      default:           prdata = '0;
    endcase
  end

  // item intake and classification
  ssfr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_operation (in_operation),
    .in_frequency (in_frequency),
    .max_freq     (max_freq_r),
    .cmd_pop      (cmd_pop),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd)
  );

  // ramp engine and result register
  ssfr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop),
    .step_size        (step_size_r),
    .step_interval    (step_interval_r),
    .start_freq       (start_freq_r),
    .duty_setting     (duty_setting_r),
    .empty            (empty),
    .pop              (pop),
    .out_current_freq (out_current_freq),
    .out_target_freq  (out_target_freq),
    .out_period_us    (out_period_us),
    .out_duty_out     (out_duty_out),
    .out_output_on    (out_output_on),
    .out_status       (out_status)
  );

endmodule

`default_nettype wire

// File: tb/soft_start_frequency_ramp_tb.sv
// self-checking testbench for the soft start frequency ramp generator
`timescale 1ns / 1ps

module soft_start_frequency_ramp_tb;
  import ssfr_pkg::*;

  localparam int HANG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 30;

  // one command item and one ramp status reading
  typedef struct packed {
    op_t                op;
    logic signed [15:0] freq;
  } cmd_item_t;

  typedef struct packed {
    logic [14:0] current;
    logic [14:0] target;
    logic [19:0] period;
    logic [9:0]  duty;
    logic        on;
    logic        status;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [1:0] in_operation = '0;
  logic signed [15:0] in_frequency = '0;
  logic empty;
  logic pop = 1'b0;
  logic [14:0] out_current_freq;
  logic [14:0] out_target_freq;
  logic [19:0] out_period_us;
  logic [9:0] out_duty_out;
  logic out_output_on;
  logic out_status;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  soft_start_frequency_ramp dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_operation(in_operation), .in_frequency(in_frequency),
    .empty(empty), .pop(pop),
    .out_current_freq(out_current_freq), .out_target_freq(out_target_freq),
    .out_period_us(out_period_us), .out_duty_out(out_duty_out),
    .out_output_on(out_output_on), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // register shadow
  logic [14:0] lim_freq;
  logic [14:0] step_hz;
  logic [15:0] step_ticks;
  logic [14:0] launch_freq;
  logic [9:0]  duty_level;

  // ramp state shadow
  logic [14:0] target_hz;
  logic [14:0] current_hz;
  logic [15:0] tick_count;
  logic        restart_armed;
  logic        wave_on;

  // target that the queued set items leave behind
  logic [14:0] queued_target;

  cmd_item_t pending_items[$];
  reading_t  expected_readings[$];
  int mismatches = 0;

  // active flag update when a frequency is applied
  function automatic void apply_freq(logic [14:0] f);
    if (f == '0) begin
      wave_on = 1'b0;
    end else if (1000000 / int'(f) >= 2) begin
      wave_on = 1'b1;
    end
  endfunction

  function automatic void start_ramp();
    current_hz = launch_freq;
    apply_freq(current_hz);
    tick_count = '0;
  endfunction

  // next state and reading for one accepted item
  function automatic reading_t predict_reading(cmd_item_t it);
    reading_t r;
    logic [15:0] raw;
    logic [16:0] nxt;
    r = '0;
    raw = it.freq;
    case (it.op)
      OP_TICK: begin
        if (tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
        if (target_hz != '0 && current_hz < target_hz && tick_count >= step_ticks) begin
          nxt = 17'(current_hz) + 17'(step_hz);
          if (nxt > 17'(target_hz)) nxt = 17'(target_hz);
          current_hz = nxt[14:0];
          apply_freq(current_hz);
          tick_count = '0;
          if (current_hz >= target_hz) restart_armed = 1'b0;
        end
      end
      OP_SET: begin
        if (raw[15] || raw[14:0] > lim_freq) begin
          r.status = 1'b1;
        end else if (raw[14:0] != target_hz) begin
          target_hz = raw[14:0];
          if (target_hz == '0) begin
            current_hz = '0;
            apply_freq('0);
          end else if (!restart_armed) begin
            start_ramp();
          end
        end
      end
      OP_RESTART: begin
        if (target_hz != '0) begin
          restart_armed = 1'b1;
          start_ramp();
        end
      end
      default: ;
    endcase
    r.current = current_hz;
    r.target = target_hz;
    r.period = (wave_on && current_hz != '0) ? 20'(1000000 / int'(current_hz)) : '0;
    r.duty = wave_on ? duty_level : '0;
    r.on = wave_on;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  function automatic int draw_gap(bit steady);
    return steady ? 0 : $urandom_range(0, 3);
  endfunction

  // input driver
  cmd_item_t on_wire;
  int in_gap = 0;
  bit in_steady = 1'b0;

  always @(posedge clk) begin
    int g;
    if (!rst_n) begin
      push <= 1'b0;
      in_gap <= 0;
    end else if (push && !full) begin
      expected_readings.push_back(predict_reading(on_wire));
      if ($urandom_range(0, 49) == 0) in_steady = !in_steady;
      g = draw_gap(in_steady);
      if (g == 0 && pending_items.size() != 0) begin
        on_wire <= pending_items[0];
        in_operation <= pending_items[0].op;
        in_frequency <= pending_items[0].freq;
        void'(pending_items.pop_front());
      end else begin
        push <= 1'b0;
        in_gap <= g;
      end
    end else if (!push) begin
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
      end else if (pending_items.size() != 0) begin
        on_wire <= pending_items[0];
        in_operation <= pending_items[0].op;
        in_frequency <= pending_items[0].freq;
        void'(pending_items.pop_front());
        push <= 1'b1;
      end
    end
  end

  // result monitor
  int pop_gap = 0;
  bit out_steady = 1'b0;

  always @(posedge clk) begin
    reading_t want;
    int g;
    if (!rst_n) begin
      pop <= 1'b0;
      pop_gap <= 0;
    end else if (pop && !empty) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected result, current_freq", out_current_freq, 0);
      end else begin
        want = expected_readings.pop_front();
        if (out_current_freq !== want.current)
          report_mismatch("current_freq", out_current_freq, want.current);
        if (out_target_freq !== want.target)
          report_mismatch("target_freq", out_target_freq, want.target);
        if (out_period_us !== want.period)
          report_mismatch("period_us", out_period_us, want.period);
        if (out_duty_out !== want.duty)
          report_mismatch("duty_out", out_duty_out, want.duty);
        if (out_output_on !== want.on)
          report_mismatch("output_on", out_output_on, want.on);
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
      end
      if ($urandom_range(0, 49) == 0) out_steady = !out_steady;
      g = draw_gap(out_steady);
      pop_gap <= g;
      pop <= (g == 0);
    end else if (!pop) begin
      if (pop_gap != 0) pop_gap <= pop_gap - 1;
      else pop <= 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || (psel && penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= HANG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // register write over the configuration port
  task automatic write_reg(reg_idx_t idx, int unsigned value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_BITS'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MAX_FREQ:      lim_freq = 15'(value);
      REG_STEP_SIZE:     step_hz = 15'(value);
      REG_STEP_INTERVAL: step_ticks = 16'(value);
      REG_START_FREQ:    launch_freq = 15'(value);
      REG_DUTY_SETTING:  duty_level = 10'(value);
      default: ;
    endcase
  endtask

  task automatic write_all(int unsigned mx, int unsigned st, int unsigned iv,
                           int unsigned sf, int unsigned dt);
    write_reg(REG_MAX_FREQ, mx);
    write_reg(REG_STEP_SIZE, st);
    write_reg(REG_STEP_INTERVAL, iv);
    write_reg(REG_START_FREQ, sf);
    write_reg(REG_DUTY_SETTING, dt);
  endtask

  function automatic void add_item(op_t op, logic signed [15:0] f);
    cmd_item_t it;
    it.op = op;
    it.freq = f;
    if (op == OP_SET && !f[15] && f[14:0] <= lim_freq) queued_target = f[14:0];
    pending_items.push_back(it);
  endfunction

  // mostly ticks and in-range targets, some rejects, restarts and unused codes
  task automatic add_random_items(int count);
    int roll;
    int pick;
    logic signed [15:0] f;
    op_t op;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      f = 16'($urandom);
      if (roll < 55) begin
        op = OP_TICK;
      end else if (roll < 82) begin
        op = OP_SET;
        pick = $urandom_range(0, 99);
        if (pick < 60) f = 16'($urandom_range(0, int'(lim_freq)));
        else if (pick < 70) f = 16'(queued_target);
        else if (pick < 78) f = '0;
        else if (pick < 89 || lim_freq == 15'h7FFF) f = -16'sd1 - 16'($urandom_range(0, 32767));
        else f = 16'($urandom_range(int'(lim_freq) + 1, 32767));
      end else if (roll < 96) begin
        op = OP_RESTART;
      end else begin
        op = OP_NONE;
      end
      add_item(op, f);
    end
  endtask

  // wait until every queued item has been taken and answered
  // sampled on the falling edge so that driver and monitor updates have settled
  task automatic drain();
    while (pending_items.size() != 0 || push || expected_readings.size() != 0)
      @(negedge clk);
  endtask

  // stimulus sequence
  initial begin
    lim_freq = 15'd1000;
    step_hz = 15'd10;
    step_ticks = 16'd100;
    launch_freq = 15'd1;
    duty_level = 10'd512;
    target_hz = '0;
    current_hz = '0;
    tick_count = '0;
    restart_armed = 1'b0;
    wave_on = 1'b0;
    queued_target = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // defaults: rejects, ignored commands, restart pending across a new target
    add_item(OP_TICK, 16'sh7FFF);
    add_item(OP_SET, -16'sd32768);
    add_item(OP_SET, 16'sd1001);
    add_item(OP_NONE, -16'sd1);
    add_item(OP_RESTART, 16'sd0);
    add_item(OP_SET, 16'sd0);
    add_item(OP_SET, 16'sd1000);
    add_item(OP_TICK, 16'sd0);
    add_item(OP_RESTART, 16'sd0);
    add_item(OP_SET, 16'sd600);
    add_item(OP_SET, 16'sd600);
    add_item(OP_SET, 16'sd0);
    add_item(OP_TICK, 16'sd0);
    add_item(OP_SET, 16'sd32767);
    add_item(OP_SET, -16'sd1);
    drain();

    // step interval zero with a step that clamps to the target
    write_all(32767, 32767, 0, 1, 1023);
    add_item(OP_SET, 16'sd32767);
    add_item(OP_TICK, 16'sd0);
    add_item(OP_TICK, 16'sd0);
    add_item(OP_SET, 16'sd20000);
    add_item(OP_TICK, 16'sd0);
    add_item(OP_RESTART, 16'sd0);
    add_item(OP_TICK, 16'sd0);
    add_item(OP_SET, 16'sd0);
    drain();

    // start frequency above the target
    write_all(32767, 1, 1, 32767, 0);
    add_item(OP_SET, 16'sd5);
    add_item(OP_TICK, 16'sd0);
    add_item(OP_TICK, 16'sd0);
    add_item(OP_SET, 16'sd0);
    drain();

    // random phases: lowest settings, highest settings, then mixed
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        write_all(0, 1, 1, 1, 0);
      end else if (ph == 1) begin
        write_all(32767, 32767, 65535, 32767, 1023);
      end else begin
        write_all(($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(20, 3000),
                  ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 400),
                  $urandom_range(1, 6),
                  ($urandom_range(0, 4) == 0) ? 32767 : $urandom_range(1, 500),
                  $urandom_range(0, 1023));
      end
      add_random_items(80);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
